[rtl/tdoc_pkg.sv]
// Shared types and constants of the TEC drive output controller.
`timescale 1ns / 1ps
package tdoc_pkg;

  // Configuration port geometry
  localparam int TDOC_CFG_IW = 3;
  localparam int TDOC_CFG_DW = 17;

  // Serial divider geometry
  localparam int TDOC_DVD_W = 32;
  localparam int TDOC_DSR_W = 16;

  // Register indexes
  localparam logic [TDOC_CFG_IW-1:0] CFG_PERIOD     = 3'd0;
  localparam logic [TDOC_CFG_IW-1:0] CFG_CMD_LIMIT  = 3'd1;
  localparam logic [TDOC_CFG_IW-1:0] CFG_DAC_VREF   = 3'd2;
  localparam logic [TDOC_CFG_IW-1:0] CFG_DAC_FS     = 3'd3;
  localparam logic [TDOC_CFG_IW-1:0] CFG_SAFE_VSET  = 3'd4;
  localparam logic [TDOC_CFG_IW-1:0] CFG_ADC_VREF   = 3'd5;
  localparam logic [TDOC_CFG_IW-1:0] CFG_ADC_FS     = 3'd6;
  localparam logic [TDOC_CFG_IW-1:0] CFG_AVG_SAMPLES = 3'd7;

  // Command codes
  localparam logic [2:0] MODE_INIT     = 3'd0;
  localparam logic [2:0] MODE_ENABLE   = 3'd1;
  localparam logic [2:0] MODE_DISABLE  = 3'd2;
  localparam logic [2:0] MODE_SETPOINT = 3'd3;
  localparam logic [2:0] MODE_PWM      = 3'd4;
  localparam logic [2:0] MODE_SAMPLE   = 3'd5;

  // Drive state codes
  localparam logic [1:0] ST_OFF   = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  // Permille scale of the PWM command
  localparam logic [TDOC_DSR_W-1:0] TDOC_PERMILLE = 16'd1000;

  // Period saturation limits
  localparam logic [16:0] PERIOD_MIN = 17'd2;
  localparam logic [16:0] PERIOD_MAX = 17'd65536;

  typedef struct packed {
    logic [16:0] pwm_period;
    logic [9:0]  command_limit_permille;
    logic [15:0] dac_vref_mv;
    logic [15:0] dac_full_scale;
    logic [15:0] safe_vset_mv;
    logic [15:0] adc_vref_mv;
    logic [15:0] adc_full_scale;
    logic [7:0]  average_samples;
  } tdoc_cfg_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [15:0]        setpoint_mv;
    logic signed [15:0] command_permille;
    logic [15:0]        adc_code;
    logic               hw_error;
  } tdoc_req_t;

  typedef struct packed {
    logic [1:0]  hw_state;
    logic        output_on;
    logic [15:0] dac_code;
    logic [15:0] pwm_compare;
    logic [15:0] average_mv;
    logic        average_valid;
  } tdoc_rsp_t;

endpackage

[rtl/tec_drive_output_controller_top.sv]
// Top level of the TEC drive output controller: configuration registers and sequencer.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on in_valid/in_stall/in_data, one command each (init, enable,
//   disable, setpoint, PWM command, ADC sample). Each request yields exactly one
//   result on out_valid/out_stall/out_data carrying drive state, output enable,
//   DAC code, compare value and, for samples, the completed average.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata, one register
//   per cycle; the user must write it only while no request is in flight, as
//   the block itself does not enforce this. A command without arithmetic goes
//   from decode straight to the result step; one that needs a DAC code, a compare
//   value or a sample conversion passes through multiply, add and the serial
//   divider, and a sample that completes an average uses the divider a second
//   time; the next request is taken once the previous one leaves the sequencer.
//   One request is processed at a time; in_stall stays high meanwhile.
//   Reset (rst_n low, synchronous) sets the drive state to off, clears DAC code,
//   compare value and sample accumulation, and loads the default configuration.
//   A result waiting under out_stall is held; the next request may still be
//   accepted and runs until its own result is ready, then waits for the register.
module tec_drive_output_controller_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tdoc_pkg::TDOC_CFG_IW-1:0] cfg_index,
  input  logic [tdoc_pkg::TDOC_CFG_DW-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tdoc_pkg::tdoc_req_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tdoc_pkg::tdoc_rsp_t              out_data
);
  import tdoc_pkg::*;

  tdoc_cfg_t cfg_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period             <= 17'd1000;
      cfg_r.command_limit_permille <= 10'd950;
      cfg_r.dac_vref_mv            <= 16'd3300;
      cfg_r.dac_full_scale         <= 16'd4095;
      cfg_r.safe_vset_mv           <= 16'd0;
      cfg_r.adc_vref_mv            <= 16'd3300;
      cfg_r.adc_full_scale         <= 16'd4095;
      cfg_r.average_samples        <= 8'd8;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PERIOD:      cfg_r.pwm_period             <= cfg_wdata;
        CFG_CMD_LIMIT:   cfg_r.command_limit_permille <= cfg_wdata[9:0];
        CFG_DAC_VREF:    cfg_r.dac_vref_mv            <= cfg_wdata[15:0];
        CFG_DAC_FS:      cfg_r.dac_full_scale         <= cfg_wdata[15:0];
        CFG_SAFE_VSET:   cfg_r.safe_vset_mv           <= cfg_wdata[15:0];
        CFG_ADC_VREF:    cfg_r.adc_vref_mv            <= cfg_wdata[15:0];
        CFG_ADC_FS:      cfg_r.adc_full_scale         <= cfg_wdata[15:0];
        CFG_AVG_SAMPLES: cfg_r.average_samples        <= cfg_wdata[7:0];
      endcase
    end
  end

  tdoc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/tdoc_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tdoc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tdoc_pkg::TDOC_DVD_W-1:0] dividend,
  input  logic [tdoc_pkg::TDOC_DSR_W-1:0] divisor,
  output logic [tdoc_pkg::TDOC_DVD_W-1:0] quotient,
  output logic                            done
);
  import tdoc_pkg::*;

  localparam int CW = $clog2(TDOC_DVD_W);
  localparam logic [CW-1:0] LAST = CW'(TDOC_DVD_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  logic [TDOC_DSR_W-1:0] rem_r;
  logic [TDOC_DSR_W-1:0] dsr_r;
  logic [TDOC_DVD_W-1:0] quo_r;

  logic [TDOC_DSR_W:0]   shifted;
  logic                  fits;
  logic [TDOC_DSR_W:0]   diff;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    shifted = {rem_r, quo_r[TDOC_DVD_W-1]};
    fits    = shifted >= {1'b0, dsr_r};
    diff    = shifted - {1'b0, dsr_r};
  end

  // Advance one bit per cycle while busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[TDOC_DVD_W-2:0], fits};
      rem_r <= fits ? diff[TDOC_DSR_W-1:0] : shifted[TDOC_DSR_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

[rtl/tdoc_seq.sv]
// Command sequencer: decode, shared multiplier, divider steps and result register.
`timescale 1ns / 1ps
module tdoc_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  tdoc_pkg::tdoc_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  tdoc_pkg::tdoc_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tdoc_pkg::tdoc_rsp_t out_data
);
  import tdoc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_MUL, S_ADD, S_GO, S_WAIT, S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {OP_NONE, OP_DAC, OP_PWM, OP_ADC} op_t;

  seq_state_t state_r;
  op_t        op_r;
  tdoc_req_t  item_r;
  tdoc_rsp_t  out_r;
  logic       out_valid_r;

  // Architectural state
  logic [1:0]  drv_st_r;
  logic [15:0] dac_r;
  logic [15:0] cmp_r;
  logic        run_r;
  logic [23:0] sum_r;
  logic [7:0]  cnt_r;
  logic [15:0] avg_r;
  logic        avg_vld_r;
  logic        avg_phase_r;
  logic        pwm_neg_r;

  // Shared arithmetic operands
  logic [15:0]           a_r;
  logic [15:0]           b_r;
  logic [15:0]           add_r;
  logic [31:0]           prod_r;
  logic [TDOC_DVD_W-1:0] dvd_r;
  logic [TDOC_DSR_W-1:0] dsr_r;

  logic                  div_start;
  logic                  div_done;
  logic [TDOC_DVD_W-1:0] quo;

  // Effective configuration values
  logic [16:0] eff_p;
  logic [15:0] center;
  logic [15:0] p_m1;
  logic [15:0] dac_vref_eff;
  logic [15:0] adc_fs_eff;
  logic [7:0]  n_eff;

  // Decode outputs
  op_t         dec_op;
  logic [1:0]  dec_st;
  logic        dec_run;
  logic        dec_center;
  logic        dec_clr;
  logic        dec_zero_avg;
  logic        fault;
  logic        err;
  logic [15:0] dac_mv;
  logic [15:0] dac_lim;
  logic [15:0] code_lim;
  logic [15:0] dec_a;
  logic [15:0] dec_b;
  logic [15:0] dec_add;
  logic [15:0] dec_dsr;

  // PWM command clamp
  logic signed [16:0] lim_s;
  logic signed [16:0] cmd_s;
  logic signed [16:0] cmd_c;
  logic [16:0]        cmd_abs;

  // Post-division results
  logic [17:0] cmp_wide;
  logic [15:0] cmp_clamped;
  logic [23:0] sum_nxt;
  logic [7:0]  cnt_nxt;

  // Saturate period and guard zero divisors
  always_comb begin
    if (cfg.pwm_period < PERIOD_MIN) begin
      eff_p = PERIOD_MIN;
    end else if (cfg.pwm_period > PERIOD_MAX) begin
      eff_p = PERIOD_MAX;
    end else begin
      eff_p = cfg.pwm_period;
    end
    center       = eff_p[16:1];
    p_m1         = 16'(eff_p - 17'd1);
    dac_vref_eff = (cfg.dac_vref_mv == '0) ? 16'd1 : cfg.dac_vref_mv;
    adc_fs_eff   = (cfg.adc_full_scale == '0) ? 16'd1 : cfg.adc_full_scale;
    n_eff        = (cfg.average_samples == '0) ? 8'd1 : cfg.average_samples;
  end

  // Decode the command against the current drive state
  always_comb begin
    fault        = (drv_st_r == ST_FAULT);
    err          = item_r.hw_error;
    dec_op       = OP_NONE;
    dec_st       = drv_st_r;
    dec_run      = run_r;
    dec_center   = 1'b0;
    dec_clr      = 1'b0;
    dec_zero_avg = 1'b0;
    dac_mv       = cfg.safe_vset_mv;
    unique case (item_r.mode)
      MODE_INIT: begin
        dec_center = 1'b1;
        dec_run    = 1'b0;
        dec_clr    = 1'b1;
        dec_op     = OP_DAC;
        dec_st     = err ? ST_FAULT : ST_READY;
      end
      MODE_ENABLE: begin
        if (!fault && drv_st_r != ST_RUN) begin
          dec_center = 1'b1;
          if (err) begin
            dec_run = 1'b0;
            dec_st  = ST_FAULT;
            dec_clr = 1'b1;
            dec_op  = OP_DAC;
          end else begin
            dec_run = 1'b1;
            dec_st  = ST_RUN;
          end
        end
      end
      MODE_DISABLE: begin
        dec_center = 1'b1;
        dec_run    = 1'b0;
        dec_op     = OP_DAC;
        dec_st     = (fault || err) ? ST_FAULT : ST_OFF;
        dec_clr    = err;
      end
      MODE_SETPOINT: begin
        if (!fault) begin
          dec_op = OP_DAC;
          if (err) begin
            dec_st  = ST_FAULT;
            dec_run = 1'b0;
            dec_clr = 1'b1;
          end else begin
            dac_mv = item_r.setpoint_mv;
          end
        end
      end
      MODE_PWM: begin
        if (!fault) begin
          dec_op = OP_PWM;
        end
      end
      MODE_SAMPLE: begin
        if (fault || err) begin
          dec_zero_avg = 1'b1;
          dec_clr      = 1'b1;
          if (err) begin
            dec_run = 1'b0;
            dec_st  = ST_FAULT;
            dec_op  = OP_DAC;
          end
        end else begin
          dec_op = OP_ADC;
        end
      end
      default: begin
      end
    endcase
  end

  // Clamp inputs and choose operands for the shared multiplier and divider
  always_comb begin
    dac_lim  = (dac_mv > cfg.dac_vref_mv) ? cfg.dac_vref_mv : dac_mv;
    code_lim = (item_r.adc_code > cfg.adc_full_scale) ? cfg.adc_full_scale : item_r.adc_code;
    lim_s    = $signed({7'b0, cfg.command_limit_permille});
    cmd_s    = $signed({item_r.command_permille[15], item_r.command_permille});
    if (cmd_s > lim_s) begin
      cmd_c = lim_s;
    end else if (cmd_s < -lim_s) begin
      cmd_c = -lim_s;
    end else begin
      cmd_c = cmd_s;
    end
    cmd_abs = cmd_c[16] ? 17'(-cmd_c) : 17'(cmd_c);
    unique case (dec_op)
      OP_PWM: begin
        dec_a   = center;
        dec_b   = {6'b0, cmd_abs[9:0]};
        dec_add = '0;
        dec_dsr = TDOC_PERMILLE;
      end
      OP_ADC: begin
        dec_a   = code_lim;
        dec_b   = cfg.adc_vref_mv;
        dec_add = {1'b0, adc_fs_eff[15:1]};
        dec_dsr = adc_fs_eff;
      end
      default: begin
        dec_a   = dac_lim;
        dec_b   = cfg.dac_full_scale;
        dec_add = {1'b0, dac_vref_eff[15:1]};
        dec_dsr = dac_vref_eff;
      end
    endcase
  end

  // Finish the compare value and the running sum from the quotient
  always_comb begin
    cmp_wide = pwm_neg_r ? ({2'b0, center} - quo[17:0]) : ({2'b0, center} + quo[17:0]);
    // a negative offset that reaches or passes the center clamps to one
    if (pwm_neg_r && (quo[17:0] >= {2'b0, center})) begin
      cmp_clamped = 16'd1;
    end else if (cmp_wide > {2'b0, p_m1}) begin
      cmp_clamped = p_m1;
    end else begin
      cmp_clamped = cmp_wide[15:0];
    end
    sum_nxt = sum_r + quo[23:0];
    cnt_nxt = cnt_r + 8'd1;
  end

  assign div_start = (state_r == S_GO);

  tdoc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_r),
    .divisor  (dsr_r),
    .quotient (quo),
    .done     (div_done)
  );

  // Sequencer, drive state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_NONE;
      out_valid_r <= 1'b0;
      drv_st_r    <= ST_OFF;
      dac_r       <= '0;
      cmp_r       <= '0;
      run_r       <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      avg_r       <= '0;
      avg_vld_r   <= 1'b0;
      avg_phase_r <= 1'b0;
      pwm_neg_r   <= 1'b0;
    end else begin
      // drop a taken result unless a new one replaces it
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          op_r        <= dec_op;
          drv_st_r    <= dec_st;
          run_r       <= dec_run;
          avg_r       <= '0;
          avg_vld_r   <= dec_zero_avg;
          avg_phase_r <= 1'b0;
          pwm_neg_r   <= cmd_c[16];
          if (dec_center) begin
            cmp_r <= center;
          end
          if (dec_clr) begin
            sum_r <= '0;
            cnt_r <= '0;
          end
          a_r     <= dec_a;
          b_r     <= dec_b;
          add_r   <= dec_add;
          dsr_r   <= dec_dsr;
          state_r <= (dec_op == OP_NONE) ? S_DONE : S_MUL;
        end
        S_MUL: begin
          prod_r  <= a_r * b_r;
          state_r <= S_ADD;
        end
        S_ADD: begin
          dvd_r   <= prod_r + {16'b0, add_r};
          state_r <= S_GO;
        end
        S_GO: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            unique case (op_r)
              OP_PWM: begin
                cmp_r   <= cmp_clamped;
                state_r <= S_DONE;
              end
              OP_ADC: begin
                if (avg_phase_r) begin
                  avg_r     <= quo[15:0];
                  avg_vld_r <= 1'b1;
                  state_r   <= S_DONE;
                end else if (cnt_nxt >= n_eff) begin
                  // average complete: divide the sum by the sample count
                  dvd_r       <= {8'b0, sum_nxt} + {25'b0, n_eff[7:1]};
                  dsr_r       <= {8'b0, n_eff};
                  sum_r       <= '0;
                  cnt_r       <= '0;
                  avg_phase_r <= 1'b1;
                  state_r     <= S_GO;
                end else begin
                  sum_r   <= sum_nxt;
                  cnt_r   <= cnt_nxt;
                  state_r <= S_DONE;
                end
              end
              default: begin
                dac_r   <= (quo > {16'b0, cfg.dac_full_scale}) ? cfg.dac_full_scale : quo[15:0];
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          // hold until the result register is free
          if (!out_valid_r || !out_stall) begin
            out_r.hw_state      <= drv_st_r;
            out_r.output_on     <= run_r;
            out_r.dac_code      <= dac_r;
            out_r.pwm_compare   <= cmp_r;
            out_r.average_mv    <= avg_r;
            out_r.average_valid <= avg_vld_r;
            out_valid_r         <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer took a request but did not go busy");

  a_run_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    run_r == (drv_st_r == ST_RUN))
    else $error("output enable disagrees with drive state");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_WAIT)
    else $error("divider finished outside the wait step");

  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.average_valid |-> out_r.average_mv == '0)
    else $error("average field nonzero without average_valid");

endmodule

[dv/tec_drive_output_controller_top_tb.sv]
// Self-checking testbench of the TEC drive output controller: directed table, then random requests.
`timescale 1ns / 1ps
module tec_drive_output_controller_top_tb;
  import tdoc_pkg::*;

  // Command codes the block leaves unused
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  localparam int IDLE_PCT     = 6;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 100;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 232;
  localparam int DIR_ROWS     = 25;
  localparam int SHOWN_MAX    = 10;

  localparam tdoc_cfg_t CFG_RESET = '{17'd1000, 10'd950, 16'd3300, 16'd4095,
                                      16'd0, 16'd3300, 16'd4095, 8'd8};
  localparam tdoc_rsp_t NO_RSP = '0;

  typedef struct packed {
    tdoc_req_t req;
    logic      typed;
    tdoc_rsp_t rsp;
  } dir_row_t;

  // Directed requests at reset configuration; typed results only where obvious
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{MODE_SPARE6, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1,
      '{ST_OFF, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{'{MODE_PWM, 16'h0000, 16'h7FFF, 16'h0000, 1'b0}, 1'b1,
      '{ST_OFF, 1'b0, 16'd0, 16'd975, 16'd0, 1'b0}},
    '{'{MODE_PWM, 16'h0000, 16'h8000, 16'h0000, 1'b0}, 1'b1,
      '{ST_OFF, 1'b0, 16'd0, 16'd25, 16'd0, 1'b0}},
    '{'{MODE_INIT, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1,
      '{ST_READY, 1'b0, 16'd0, 16'd500, 16'd0, 1'b0}},
    '{'{MODE_SETPOINT, 16'hFFFF, 16'h0000, 16'h0000, 1'b0}, 1'b1,
      '{ST_READY, 1'b0, 16'd4095, 16'd500, 16'd0, 1'b0}},
    '{'{MODE_SETPOINT, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1,
      '{ST_READY, 1'b0, 16'd0, 16'd500, 16'd0, 1'b0}},
    '{'{MODE_SETPOINT, 16'd1650, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_ENABLE, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_PWM, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'd100, 1'b1}, 1'b0, NO_RSP},
    '{'{MODE_ENABLE, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'd2000, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_DISABLE, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_INIT, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_RSP},
    '{'{MODE_INIT, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_DISABLE, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_RSP},
    '{'{MODE_INIT, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_SETPOINT, 16'd3000, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_RSP},
    '{'{MODE_INIT, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_ENABLE, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_RSP},
    '{'{MODE_INIT, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_PWM, 16'h0000, 16'd333, 16'h0000, 1'b1}, 1'b0, NO_RSP},
    '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'd4095, 1'b0}, 1'b0, NO_RSP},
    '{'{MODE_SAMPLE, 16'h0000, 16'h0000, 16'd2048, 1'b0}, 1'b0, NO_RSP}
  };

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [TDOC_CFG_IW-1:0] cfg_index = '0;
  logic [TDOC_CFG_DW-1:0] cfg_wdata = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  tdoc_req_t              in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  tdoc_rsp_t              out_data;

  // Shadow registers and drive state of the expected behavior
  tdoc_cfg_t   regs = CFG_RESET;
  logic [1:0]  drv_state = ST_OFF;
  logic [15:0] drv_dac = '0;
  logic [15:0] drv_cmp = '0;
  logic        drv_on = 1'b0;
  logic [23:0] acc_sum = '0;
  logic [7:0]  acc_cnt = '0;

  tdoc_rsp_t   pending_rsp [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  tec_drive_output_controller_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Saturate the period to its usable range
  function automatic logic [16:0] period_used();
    if (regs.pwm_period < PERIOD_MIN) return PERIOD_MIN;
    if (regs.pwm_period > PERIOD_MAX) return PERIOD_MAX;
    return regs.pwm_period;
  endfunction

  function automatic void set_center();
    drv_cmp = 16'(period_used() / 2);
  endfunction

  // Convert millivolts to a rounded, clamped DAC code
  function automatic void drive_dac_mv(logic [15:0] mv);
    longint unsigned div, lim, code;
    div  = (regs.dac_vref_mv == 0) ? 1 : regs.dac_vref_mv;
    lim  = (mv > regs.dac_vref_mv) ? regs.dac_vref_mv : mv;
    code = (lim * regs.dac_full_scale + div / 2) / div;
    if (code > regs.dac_full_scale) code = regs.dac_full_scale;
    drv_dac = code[15:0];
  endfunction

  function automatic void trip_fault();
    drv_on    = 1'b0;
    drive_dac_mv(regs.safe_vset_mv);
    drv_state = ST_FAULT;
    acc_sum   = '0;
    acc_cnt   = '0;
  endfunction

  // Map a signed permille command to a compare value around the center
  function automatic void apply_pwm(logic signed [15:0] cmd_in);
    int p, half, lim, cmd, cmp;
    p    = int'(period_used());
    half = p / 2;
    lim  = int'(regs.command_limit_permille);
    cmd  = int'(cmd_in);
    if (cmd > lim) cmd = lim;
    else if (cmd < -lim) cmd = -lim;
    cmp = half + (half * cmd) / int'(TDOC_PERMILLE);
    if (cmp < 1) cmp = 1;
    else if (cmp > p - 1) cmp = p - 1;
    drv_cmp = cmp[15:0];
  endfunction

  // Advance the expected drive state by one request and return its result
  function automatic tdoc_rsp_t predict_drive(tdoc_req_t r);
    tdoc_rsp_t       res;
    longint unsigned fs, code, mv, n, mean;
    res = '0;
    case (r.mode)
      MODE_INIT: begin
        drv_state = ST_OFF;
        set_center();
        drv_on  = 1'b0;
        acc_sum = '0;
        acc_cnt = '0;
        drive_dac_mv(regs.safe_vset_mv);
        if (r.hw_error) trip_fault();
        else drv_state = ST_READY;
      end
      MODE_ENABLE: begin
        if (drv_state != ST_FAULT && drv_state != ST_RUN) begin
          set_center();
          if (r.hw_error) trip_fault();
          else begin
            drv_on    = 1'b1;
            drv_state = ST_RUN;
          end
        end
      end
      MODE_DISABLE: begin
        set_center();
        drv_on = 1'b0;
        drive_dac_mv(regs.safe_vset_mv);
        if (drv_state != ST_FAULT) drv_state = ST_OFF;
        if (r.hw_error) trip_fault();
      end
      MODE_SETPOINT: begin
        if (drv_state != ST_FAULT) begin
          drive_dac_mv(r.setpoint_mv);
          if (r.hw_error) trip_fault();
        end
      end
      MODE_PWM: begin
        if (drv_state != ST_FAULT) apply_pwm(r.command_permille);
      end
      MODE_SAMPLE: begin
        if (drv_state == ST_FAULT || r.hw_error) begin
          // Fault sample: zero average completes at once
          if (r.hw_error) trip_fault();
          acc_sum = '0;
          acc_cnt = '0;
          res.average_valid = 1'b1;
        end else begin
          fs   = (regs.adc_full_scale == 0) ? 1 : regs.adc_full_scale;
          n    = (regs.average_samples == 0) ? 1 : regs.average_samples;
          code = (r.adc_code > regs.adc_full_scale) ? regs.adc_full_scale : r.adc_code;
          mv   = (code * regs.adc_vref_mv + fs / 2) / fs;
          acc_sum = 24'(acc_sum + mv);
          acc_cnt = acc_cnt + 8'd1;
          if (acc_cnt >= n) begin
            mean = (acc_sum + n / 2) / n;
            res.average_mv    = mean[15:0];
            res.average_valid = 1'b1;
            acc_sum = '0;
            acc_cnt = '0;
          end
        end
      end
      default: ;
    endcase
    res.hw_state    = drv_state;
    res.output_on   = drv_on;
    res.dac_code    = drv_dac;
    res.pwm_compare = drv_cmp;
    return res;
  endfunction

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(logic [TDOC_CFG_IW-1:0] idx, logic [TDOC_CFG_DW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_PERIOD:      regs.pwm_period             = val;
      CFG_CMD_LIMIT:   regs.command_limit_permille = val[9:0];
      CFG_DAC_VREF:    regs.dac_vref_mv            = val[15:0];
      CFG_DAC_FS:      regs.dac_full_scale         = val[15:0];
      CFG_SAFE_VSET:   regs.safe_vset_mv           = val[15:0];
      CFG_ADC_VREF:    regs.adc_vref_mv            = val[15:0];
      CFG_ADC_FS:      regs.adc_full_scale         = val[15:0];
      CFG_AVG_SAMPLES: regs.average_samples        = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(tdoc_cfg_t c);
    write_reg(CFG_PERIOD, c.pwm_period);
    write_reg(CFG_CMD_LIMIT, 17'(c.command_limit_permille));
    write_reg(CFG_DAC_VREF, 17'(c.dac_vref_mv));
    write_reg(CFG_DAC_FS, 17'(c.dac_full_scale));
    write_reg(CFG_SAFE_VSET, 17'(c.safe_vset_mv));
    write_reg(CFG_ADC_VREF, 17'(c.adc_vref_mv));
    write_reg(CFG_ADC_FS, 17'(c.adc_full_scale));
    write_reg(CFG_AVG_SAMPLES, 17'(c.average_samples));
    cfg_wr_en <= 1'b0;
  endtask

  // Register settings per phase: mid values, both extremes, zero divisors, reset, random
  function automatic tdoc_cfg_t phase_regs(int ph);
    tdoc_cfg_t c;
    case (ph)
      0: c = '{17'd1, 10'd500, 16'd2500, 16'd1023, 16'd1200, 16'd5000, 16'd1023, 8'd2};
      1: c = '{17'd2, 10'd1000, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 8'd1};
      2: c = '{17'h1FFFF, 10'd0, 16'hFFFF, 16'd1, 16'd0, 16'd1, 16'hFFFF, 8'd255};
      3: c = '{17'd0, 10'h3FF, 16'd0, 16'hFFFF, 16'd40000, 16'hFFFF, 16'd0, 8'd0};
      4: c = CFG_RESET;
      default: begin
        c.pwm_period = ($urandom_range(3) == 0) ? 17'($urandom_range(131071))
                                                : 17'($urandom_range(2, 4000));
        c.command_limit_permille = 10'($urandom);
        c.dac_vref_mv    = 16'($urandom);
        c.dac_full_scale = 16'($urandom);
        c.safe_vset_mv   = 16'($urandom);
        c.adc_vref_mv    = 16'($urandom);
        c.adc_full_scale = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(4095));
        c.average_samples = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
      end
    endcase
    return c;
  endfunction

  // Mostly well-formed commands with random content, some errors and unused codes
  function automatic tdoc_req_t random_req();
    tdoc_req_t r;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 8) r.mode = MODE_INIT;
    else if (pick < 18) r.mode = MODE_ENABLE;
    else if (pick < 25) r.mode = MODE_DISABLE;
    else if (pick < 40) r.mode = MODE_SETPOINT;
    else if (pick < 55) r.mode = MODE_PWM;
    else if (pick < 97) r.mode = MODE_SAMPLE;
    else r.mode = ($urandom_range(1) == 0) ? MODE_SPARE6 : MODE_SPARE7;
    r.setpoint_mv = ($urandom_range(1) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(regs.dac_vref_mv));
    r.command_permille = ($urandom_range(1) == 0) ? 16'($urandom)
                                                  : 16'(int'($urandom_range(2200)) - 1100);
    r.adc_code = ($urandom_range(1) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(regs.adc_full_scale));
    r.hw_error = ($urandom_range(99) < 4);
    return r;
  endfunction

  // Offer one request, hold it until taken, then queue its expected result
  task automatic send_req(tdoc_req_t r, bit use_typed, tdoc_rsp_t typed_rsp);
    tdoc_rsp_t want;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_drive(r);
    pending_rsp.push_back(use_typed ? typed_rsp : want);
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOWN_MAX)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Result side: random stall, compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    tdoc_rsp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      if (out_valid && !out_stall) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("%0t: result with no request outstanding: %p", $time, out_data);
        end else begin
          want = pending_rsp.pop_front();
          compare_field("hw_state", 16'(want.hw_state), 16'(out_data.hw_state));
          compare_field("output_on", 16'(want.output_on), 16'(out_data.output_on));
          compare_field("dac_code", want.dac_code, out_data.dac_code);
          compare_field("pwm_compare", want.pwm_compare, out_data.pwm_compare);
          compare_field("average_mv", want.average_mv, out_data.average_mv);
          compare_field("average_valid", 16'(want.average_valid),
                        16'(out_data.average_valid));
        end
      end
    end
  end

  // Watchdog: end the run when no request or result moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    tdoc_req_t lead;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table at reset configuration
    for (int i = 0; i < DIR_ROWS; i++)
      send_req(DIR_TABLE[i].req, DIR_TABLE[i].typed, DIR_TABLE[i].rsp);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      load_regs(phase_regs(ph));
      calm = (ph == 1);
      // Lead with a clean sample so a lowered threshold completes the leftover average
      lead = random_req();
      lead.mode = MODE_SAMPLE;
      lead.hw_error = 1'b0;
      send_req(lead, 1'b0, NO_RSP);
      repeat (PHASE_ITEMS - 1) send_req(random_req(), 1'b0, NO_RSP);
    end
    calm = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tdoc_pkg.sv
rtl/tdoc_div.sv
rtl/tdoc_seq.sv
rtl/tec_drive_output_controller_top.sv
dv/tec_drive_output_controller_top_tb.sv
